// ===== rtl/pp2g_pkg.sv =====
// shared constants, types and the arctangent table for the pixel phase to gray unit
// depends on nothing; imported by every module of the unit
`default_nettype none

package pp2g_pkg;

   // fixed port widths of the pixel and gray words
   localparam int IN_WIDTH  = 16;
   localparam int OUT_WIDTH = 16;

   // arithmetic configuration
   localparam int COORD_WIDTH   = 16;
   localparam int PHASE_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int ANG_TABLE_LEN = 24;
   localparam int NUM_STAGES    = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES
                                                                  : ANG_TABLE_LEN;

   // coordinates are scaled to 40 bits; cordic gain and the sqrt(2) corner need 3 more
   localparam int SCALE_SHIFT = 40 - COORD_WIDTH;
   localparam int XY_WIDTH    = 43;
   // angle in units of 2^-32 turn, magnitude stays below 2^32
   localparam int Z_WIDTH     = 34;
   localparam int ACC_WIDTH   = Z_WIDTH + 1;
   localparam int ROUND_SHIFT = 32 - PHASE_WIDTH;

   localparam logic signed [Z_WIDTH-1:0] HALF_TURN     = 34'sd2147483648;
   localparam logic signed [Z_WIDTH-1:0] NEG_HALF_TURN = -34'sd2147483648;

   localparam logic signed [ACC_WIDTH-1:0] ACC_HALF_TURN = 35'sd2147483648;
   localparam logic signed [ACC_WIDTH-1:0] ACC_ROUND     =
      ACC_WIDTH'(64'sd1 <<< (31 - PHASE_WIDTH));
   localparam logic signed [ACC_WIDTH-1:0] ACC_FULL      =
      ACC_WIDTH'((64'sd1 <<< PHASE_WIDTH) - 64'sd1);

   localparam logic [PHASE_WIDTH-1:0] PHASE_MID  = PHASE_WIDTH'(64'd1 << (PHASE_WIDTH - 1));
   localparam logic [PHASE_WIDTH-1:0] PHASE_FULL = PHASE_WIDTH'((64'd1 << PHASE_WIDTH) - 64'd1);

   // atan(2^-i) in units of 2^-32 turn, rounded to nearest
   localparam logic signed [Z_WIDTH-1:0] ATAN_TURNS [ANG_TABLE_LEN] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

   // one word in flight through the rotation pipeline
   typedef struct packed {
      logic                       special;
      logic signed [XY_WIDTH-1:0] x;
      logic signed [XY_WIDTH-1:0] y;
      logic signed [Z_WIDTH-1:0]  z;
   } cordic_word_type;

endpackage

`default_nettype wire

// ===== rtl/pp2g_prep.sv =====
// input conditioning stage: sign extension, scaling, left half plane fold, special flag
// depends on pp2g_pkg
`default_nettype none

module pp2g_prep (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire logic [pp2g_pkg::IN_WIDTH-1:0] x_coord,
   input  wire logic [pp2g_pkg::IN_WIDTH-1:0] y_coord,
   input  wire logic                         pixel_invalid,
   output logic                              out_valid,
   output pp2g_pkg::cordic_word_type         out_word
);
   import pp2g_pkg::*;

   logic                  valid_ff;
   cordic_word_type       word_ff;
   cordic_word_type       word_in;

   always_comb begin
      logic [63:0]                x_raw;
      logic [63:0]                y_raw;
      logic [COORD_WIDTH-1:0]     x_c;
      logic [COORD_WIDTH-1:0]     y_c;
      logic signed [XY_WIDTH-1:0] x_s;
      logic signed [XY_WIDTH-1:0] y_s;
      // bits above the coordinate width are ignored
      x_raw = 64'(x_coord);
      y_raw = 64'(y_coord);
      x_c   = x_raw[COORD_WIDTH-1:0];
      y_c   = y_raw[COORD_WIDTH-1:0];
      x_s   = {{(XY_WIDTH - COORD_WIDTH){x_c[COORD_WIDTH-1]}}, x_c};
      y_s   = {{(XY_WIDTH - COORD_WIDTH){y_c[COORD_WIDTH-1]}}, y_c};
      x_s   = x_s <<< SCALE_SHIFT;
      y_s   = y_s <<< SCALE_SHIFT;

      word_in.special = pixel_invalid || ((x_c == '0) && (y_c == '0));
      if (x_s < 0) begin
         word_in.x = -x_s;
         word_in.y = -y_s;
         word_in.z = (y_s >= 0) ? HALF_TURN : NEG_HALF_TURN;
      end else begin
         word_in.x = x_s;
         word_in.y = y_s;
         word_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// ===== rtl/pp2g_cordic.sv =====
// vectoring rotation pipeline, one registered micro-rotation per stage
// depends on pp2g_pkg
`default_nettype none

module pp2g_cordic (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire pp2g_pkg::cordic_word_type in_word,
   output logic                           out_valid,
   output pp2g_pkg::cordic_word_type      out_word
);
   import pp2g_pkg::*;

   logic [NUM_STAGES-1:0] stage_valid_ff;
   cordic_word_type       stage_word_ff [NUM_STAGES];

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      logic            cur_valid;
      cordic_word_type cur_word;
      cordic_word_type word_in;

      if (i == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_word  = in_word;
      end else begin : g_next
         assign cur_valid = stage_valid_ff[i-1];
         assign cur_word  = stage_word_ff[i-1];
      end

      always_comb begin
         logic signed [XY_WIDTH-1:0] xs;
         logic signed [XY_WIDTH-1:0] ys;
         xs = cur_word.x >>> i;
         ys = cur_word.y >>> i;
         word_in.special = cur_word.special;
         // rotate toward the x axis
         if (cur_word.y >= 0) begin
            word_in.x = cur_word.x + ys;
            word_in.y = cur_word.y - xs;
            word_in.z = cur_word.z + ATAN_TURNS[i];
         end else begin
            word_in.x = cur_word.x - ys;
            word_in.y = cur_word.y + xs;
            word_in.z = cur_word.z - ATAN_TURNS[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_valid_ff[i] <= 1'b0;
         end else if (advance) begin
            stage_valid_ff[i] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_word_ff[i] <= word_in;
         end
      end
   end

   assign out_valid = stage_valid_ff[NUM_STAGES-1];
   assign out_word  = stage_word_ff[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/pp2g_post.sv =====
// output stage: half turn offset, rounding, clamping, special case, output register
// depends on pp2g_pkg
`default_nettype none

module pp2g_post (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire pp2g_pkg::cordic_word_type     in_word,
   output logic                               advance,
   output logic                               out_valid,
   output logic [pp2g_pkg::OUT_WIDTH-1:0]     out_gray,
   input  wire logic                          out_ready
);
   import pp2g_pkg::*;

   logic                   valid_ff;
   logic [OUT_WIDTH-1:0]   gray_ff;
   logic [OUT_WIDTH-1:0]   gray_in;

   // whole pipeline moves when the output register is free or being taken
   assign advance = !valid_ff || out_ready;

   always_comb begin
      logic signed [ACC_WIDTH-1:0] acc;
      logic signed [ACC_WIDTH-1:0] scaled;
      logic [PHASE_WIDTH-1:0]      phase;
      acc    = ACC_WIDTH'(in_word.z) + ACC_HALF_TURN + ACC_ROUND;
      scaled = acc >>> ROUND_SHIFT;
      if (in_word.special) begin
         phase = PHASE_MID;
      end else if (acc < 0) begin
         phase = '0;
      end else if (scaled > ACC_FULL) begin
         phase = PHASE_FULL;
      end else begin
         phase = scaled[PHASE_WIDTH-1:0];
      end
      gray_in = OUT_WIDTH'(phase);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gray_ff <= gray_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_gray  = gray_ff;

endmodule

`default_nettype wire

// ===== rtl/pixel_phase_to_gray_unit.sv =====
// a req word passes the prep, rotation and output registers on its way to rsp_valid
// (18 register stages: 1 prep, 16 rotation, 1 output)
// throughput: one word per cycle unless stalled; rotation stages use 43-bit add/subtract
// backpressure stalls the whole pipeline in place, so nothing is dropped or repeated
// reset (synchronous, active high) clears every stage valid bit; data registers keep garbage
// top level: depends on pp2g_pkg, pp2g_prep, pp2g_cordic, pp2g_post
`default_nettype none

module pixel_phase_to_gray_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // pixel word in
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [pp2g_pkg::IN_WIDTH-1:0] req_x_coord,
   input  wire logic [pp2g_pkg::IN_WIDTH-1:0] req_y_coord,
   input  wire logic                          req_pixel_invalid,
   // gray word out
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [pp2g_pkg::OUT_WIDTH-1:0]     rsp_phase_gray
);
   import pp2g_pkg::*;

   // single pipeline enable, driven by the output register occupancy and rsp_ready
   logic            advance;

   logic            prep_valid;
   cordic_word_type prep_word;
   logic            rot_valid;
   cordic_word_type rot_word;

   // a word enters whenever the pipeline moves
   assign req_ready = advance;

   // sign extend, scale to 40 bits, fold left half plane onto the right with a
   // half turn start angle, flag invalid pixels and the origin
   pp2g_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_valid),
      .x_coord       (req_x_coord),
      .y_coord       (req_y_coord),
      .pixel_invalid (req_pixel_invalid),
      .out_valid     (prep_valid),
      .out_word      (prep_word)
   );

   // one micro-rotation per register stage, angle accumulates in z
   pp2g_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prep_valid),
      .in_word   (prep_word),
      .out_valid (rot_valid),
      .out_word  (rot_word)
   );

   // offset by half a turn, round, clamp, substitute mid gray for special words
   pp2g_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_word   (rot_word),
      .advance   (advance),
      .out_valid (rsp_valid),
      .out_gray  (rsp_phase_gray),
      .out_ready (rsp_ready)
   );

endmodule

`default_nettype wire

// ===== bench/pixel_phase_to_gray_unit_test.sv =====
// testbench for pixel_phase_to_gray_unit: directed table then random pixel words, gray words
// checked against an in-bench cordic angle predictor; depends on pp2g_pkg and the unit's rtl
`timescale 1ns / 1ps

module pixel_phase_to_gray_unit_test;

   import pp2g_pkg::*;

   // predictor constants
   localparam int    COORD_SHIFT  = 24;          // 16-bit coords scaled to 40 bits
   localparam int    ROT_STAGES   = 16;
   localparam int    GRAY_SHIFT   = 16;          // 32-bit turn fraction down to 16 bits
   localparam longint TURN_HALF   = 64'sd2147483648;
   localparam longint GRAY_ROUND  = 64'sd32768;
   localparam longint GRAY_MAX    = 64'sd65535;
   localparam logic [OUT_WIDTH-1:0] GRAY_MID = 16'd32768;

   localparam int RANDOM_WORDS = 600;
   localparam int DRAIN_CYCLES = 40;             // pipeline is 18 deep, leave some margin

   // atan(2^-i) in 2^-32 turn
   localparam longint ARCTAN_STEP [ROT_STAGES] = '{
      536870912, 316933406, 167458907, 85004756,
      42667331,  21354465,  10679838,  5340245,
      2670163,   1335087,   667544,    333772,
      166886,    83443,     41722,     20861
   };

   typedef struct packed {
      logic [IN_WIDTH-1:0]  x;
      logic [IN_WIDTH-1:0]  y;
      logic                 invalid;
      logic                 known;       // gray typed in below, else predicted
      logic [OUT_WIDTH-1:0] gray;
   } pixel_case_type;

   typedef struct {
      logic [IN_WIDTH-1:0]  x;
      logic [IN_WIDTH-1:0]  y;
      logic                 invalid;
      logic [OUT_WIDTH-1:0] gray;
   } gray_expect_type;

   // directed stimulus: invalid pixels, the origin, extremes, axes and all four quadrants
   localparam int DIRECTED_COUNT = 24;
   localparam pixel_case_type DIRECTED_CASES [DIRECTED_COUNT] = '{
      // invalid flag wins over any coordinate
      '{16'sd1234,   -16'sd77,    1'b1, 1'b1, GRAY_MID},
      '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, GRAY_MID},
      '{16'sd32767,  16'sd32767,  1'b1, 1'b1, GRAY_MID},
      // origin, valid and flagged
      '{16'sd0,      16'sd0,      1'b0, 1'b1, GRAY_MID},
      '{16'sd0,      16'sd0,      1'b1, 1'b1, GRAY_MID},
      // positive and negative axes at full scale, plus x = -1
      '{16'sd32767,  16'sd0,      1'b0, 1'b0, 16'd0},
      '{16'sd0,      16'sd32767,  1'b0, 1'b0, 16'd0},
      '{16'sd0,      -16'sd32768, 1'b0, 1'b0, 16'd0},
      '{-16'sd32768, 16'sd0,      1'b0, 1'b0, 16'd0},  // branch cut, lands near full scale
      '{-16'sd1,     16'sd0,      1'b0, 1'b0, 16'd0},
      // corners of the coordinate range
      '{16'sd32767,  16'sd32767,  1'b0, 1'b0, 16'd0},
      '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, 16'd0},
      '{-16'sd32768, 16'sd32767,  1'b0, 1'b0, 16'd0},
      '{16'sd32767,  -16'sd32768, 1'b0, 1'b0, 16'd0},
      // unit steps around the origin
      '{16'sd1,      16'sd0,      1'b0, 1'b0, 16'd0},
      '{16'sd0,      16'sd1,      1'b0, 1'b0, 16'd0},
      '{16'sd0,      -16'sd1,     1'b0, 1'b0, 16'd0},
      '{16'sd1,      -16'sd1,     1'b0, 1'b0, 16'd0},
      '{-16'sd1,     -16'sd1,     1'b0, 1'b0, 16'd0},
      '{-16'sd1,     16'sd1,      1'b0, 1'b0, 16'd0},
      // just either side of the cut, left half plane, then close to the y axis
      '{-16'sd32768, -16'sd1,     1'b0, 1'b0, 16'd0},
      '{-16'sd32768, 16'sd1,      1'b0, 1'b0, 16'd0},
      '{-16'sd5,     -16'sd32768, 1'b0, 1'b0, 16'd0},
      '{16'sd5,      16'sd32767,  1'b0, 1'b0, 16'd0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [IN_WIDTH-1:0]  req_x_coord;
   logic [IN_WIDTH-1:0]  req_y_coord;
   logic                 req_pixel_invalid;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [OUT_WIDTH-1:0] rsp_phase_gray;

   gray_expect_type gray_expect_q [$];
   int  mismatch_count = 0;
   int  words_sent     = 0;
   int  words_checked  = 0;
   int  stall_left     = 0;
   bit  steady_flow    = 0;   // no gaps on either side while set

   pixel_phase_to_gray_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_x_coord       (req_x_coord),
      .req_y_coord       (req_y_coord),
      .req_pixel_invalid (req_pixel_invalid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_phase_gray    (rsp_phase_gray)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // vectoring cordic on 40-bit scaled coords, angle in 2^-32 turn, then round to 16 bits
   function automatic logic [OUT_WIDTH-1:0] phase_to_gray(input logic [IN_WIDTH-1:0] xc,
                                                           input logic [IN_WIDTH-1:0] yc,
                                                           input logic invalid);
      longint px;
      longint py;
      longint angle;
      longint sx;
      longint sy;
      longint acc;
      longint gray;
      if (invalid || (xc == '0 && yc == '0))
         return GRAY_MID;
      px = longint'($signed(xc));
      py = longint'($signed(yc));
      px = px <<< COORD_SHIFT;
      py = py <<< COORD_SHIFT;
      angle = 0;
      // left half plane: rotate by half a turn first, sign of y picks the side of the cut
      if (px < 0) begin
         angle = (py >= 0) ? TURN_HALF : -TURN_HALF;
         px = -px;
         py = -py;
      end
      for (int i = 0; i < ROT_STAGES; i++) begin
         sx = px >>> i;
         sy = py >>> i;
         if (py >= 0) begin
            px    = px + sy;
            py    = py - sx;
            angle = angle + ARCTAN_STEP[i];
         end else begin
            px    = px - sy;
            py    = py + sx;
            angle = angle - ARCTAN_STEP[i];
         end
      end
      acc = angle + TURN_HALF + GRAY_ROUND;
      // saturate residue beyond +-pi
      if (acc < 0)
         return '0;
      gray = acc >>> GRAY_SHIFT;
      if (gray > GRAY_MAX)
         gray = GRAY_MAX;
      return OUT_WIDTH'(gray);
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (steady_flow || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [IN_WIDTH-1:0] pick_edge_value();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'hffff;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7fff;
      endcase
   endfunction

   // present one pixel word at a falling edge, hold it until accepted, then log its gray
   task automatic send_pixel(input logic [IN_WIDTH-1:0] xc, input logic [IN_WIDTH-1:0] yc,
                             input logic invalid, input logic known,
                             input logic [OUT_WIDTH-1:0] gray);
      int gap;
      gray_expect_type entry;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_x_coord       = xc;
      req_y_coord       = yc;
      req_pixel_invalid = invalid;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      entry.x       = xc;
      entry.y       = yc;
      entry.invalid = invalid;
      entry.gray    = known ? gray : phase_to_gray(xc, yc, invalid);
      gray_expect_q.push_back(entry);
      words_sent++;
   endtask

   // random pixel shapes: full range, near origin, on axes and diagonals, edges, flagged
   task automatic send_random_pixel();
      logic [IN_WIDTH-1:0] xc;
      logic [IN_WIDTH-1:0] yc;
      logic [IN_WIDTH-1:0] mag;
      logic                invalid;
      int                  roll;
      xc      = IN_WIDTH'($urandom());
      yc      = IN_WIDTH'($urandom());
      invalid = ($urandom_range(9) == 0);
      mag     = IN_WIDTH'($urandom_range(32767, 1));
      roll    = $urandom_range(99);
      if (roll < 50) begin
         // full range already drawn
      end else if (roll < 65) begin
         xc = IN_WIDTH'($urandom_range(16, 0) - 8);
         yc = IN_WIDTH'($urandom_range(16, 0) - 8);
      end else if (roll < 80) begin
         case ($urandom_range(5))
            0: begin xc = mag;  yc = '0;   end
            1: begin xc = -mag; yc = '0;   end    // negative x axis, the cut
            2: begin xc = '0;   yc = mag;  end
            3: begin xc = '0;   yc = -mag; end
            4: begin xc = mag;  yc = mag;  end
            default: begin xc = -mag; yc = mag; end
         endcase
         if ($urandom_range(1)) begin
            xc = -xc;
            yc = -yc;
         end
      end else if (roll < 90) begin
         xc = pick_edge_value();
         yc = pick_edge_value();
      end else begin
         invalid = 1'b1;
      end
      send_pixel(xc, yc, invalid, 1'b0, '0);
   endtask

   // gray word sink: random stalls unless the flow is steady
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         stall_left = pick_gap();
         rsp_ready  = (stall_left == 0);
         if (stall_left > 0)
            stall_left = stall_left - 1;
      end
   end

   // compare every accepted gray word with the oldest one logged
   always @(posedge clock) begin
      gray_expect_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gray_expect_q.size() == 0) begin
            $display("%0t: gray word with none expected: expected nothing, got %0d",
                     $time, rsp_phase_gray);
            mismatch_count++;
         end else begin
            want = gray_expect_q.pop_front();
            words_checked++;
            if (rsp_phase_gray !== want.gray) begin
               $display("%0t: gray mismatch x=%0d y=%0d invalid=%0b: expected %0d, got %0d",
                        $time, $signed(want.x), $signed(want.y), want.invalid, want.gray,
                        rsp_phase_gray);
               mismatch_count++;
            end
         end
      end
   end

   // safety net against a hung handshake
   initial begin
      #5_000_000;
      $display("timeout with %0d gray words still expected", gray_expect_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_x_coord       = '0;
      req_y_coord       = '0;
      req_pixel_invalid = 1'b0;
      rsp_ready         = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed table first
      foreach (DIRECTED_CASES[i])
         send_pixel(DIRECTED_CASES[i].x, DIRECTED_CASES[i].y, DIRECTED_CASES[i].invalid,
                    DIRECTED_CASES[i].known, DIRECTED_CASES[i].gray);

      // random words; words 100 to 199 and 400 to 499 run with no gaps at all
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady_flow = ((n / 100) == 1) || ((n / 100) == 4);
         send_random_pixel();
      end
      steady_flow = 1'b0;
      @(negedge clock);
      req_valid = 1'b0;

      // drain, then give any stray word time to show up
      while (gray_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d pixel words (%0d from the directed table), checked %0d gray words",
               words_sent, DIRECTED_COUNT, words_checked);
      $display("mismatches seen: %0d", mismatch_count);
      if (mismatch_count == 0 && gray_expect_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pp2g_pkg.sv
rtl/pp2g_prep.sv
rtl/pp2g_cordic.sv
rtl/pp2g_post.sv
rtl/pixel_phase_to_gray_unit.sv
bench/pixel_phase_to_gray_unit_test.sv
